// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect signals named clk and rst in the module that uses them.

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/clws_pkg.sv -----
`timescale 1ns / 1ps

package clws_pkg;

  // Request function codes.
  localparam logic [2:0] FUNC_CHAR     = 3'd0;
  localparam logic [2:0] FUNC_NUMBER   = 3'd1;
  localparam logic [2:0] FUNC_CLEAR    = 3'd2;
  localparam logic [2:0] FUNC_SETTINGS = 3'd3;
  localparam logic [2:0] FUNC_INIT     = 3'd4;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_FOUR_BIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_LINES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TALL_FONT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_MODE  = 3'd4;

  // Cursor mode codes; the unused code behaves as cursor off.
  localparam logic [1:0] CURSOR_OFF   = 2'd0;
  localparam logic [1:0] CURSOR_ON    = 2'd1;
  localparam logic [1:0] CURSOR_BLINK = 2'd2;

  // Command and character bytes.
  localparam logic [7:0] FSET_BASE   = 8'h30;
  localparam logic [7:0] DL_BIT      = 8'h10;
  localparam logic [7:0] FSET_N_BIT  = 8'h08;
  localparam logic [7:0] FSET_F_BIT  = 8'h04;
  localparam logic [7:0] DCTL_BASE   = 8'h08;
  localparam logic [7:0] DCTL_D_BIT  = 8'h04;
  localparam logic [7:0] DCTL_C_BIT  = 8'h02;
  localparam logic [7:0] DCTL_B_BIT  = 8'h01;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] INIT_NIBBLE = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_MINUS    = 8'h2D;

  // Binary to decimal conversion.
  localparam int BIN_W     = 32;
  localparam int DIGITS    = 10;
  localparam int CNT_W     = $clog2(BIN_W);
  localparam int DIG_IDX_W = $clog2(DIGITS);
  localparam logic [DIG_IDX_W-1:0] TOP_DIGIT = DIG_IDX_W'(DIGITS - 1);

  typedef logic [DIGITS-1:0][3:0] digit_arr_t;

  typedef struct packed {
    logic             bus_four_bit;
    logic             two_lines;
    logic             tall_font;
    logic             display_on;
    logic [1:0]       cursor_mode;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [BIN_W-1:0] mag;
  } conv_req_t;

  function automatic logic [7:0] fset_byte(input cfg_t cfg);
    logic [7:0] fs;
    fs = FSET_BASE;
    if (cfg.two_lines) fs = fs | FSET_N_BIT;
    if (cfg.tall_font) fs = fs | FSET_F_BIT;
    if (cfg.bus_four_bit) fs = fs & ~DL_BIT;
    return fs;
  endfunction

  function automatic logic [7:0] dctl_byte(input cfg_t cfg);
    logic [7:0] dc;
    dc = DCTL_BASE;
    if (cfg.display_on) dc = dc | DCTL_D_BIT;
    case (cfg.cursor_mode)
      CURSOR_ON:    dc = dc | DCTL_C_BIT;
      CURSOR_BLINK: dc = dc | DCTL_C_BIT | DCTL_B_BIT;
      default:      dc = dc;
    endcase
    return dc;
  endfunction

endpackage

// ----- src/clws_req_if.sv -----
`timescale 1ns / 1ps

interface clws_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic signed [31:0] value;

  modport source (output valid, func, value, input ready);
  modport sink (input valid, func, value, output ready);
endinterface

// ----- src/clws_strobe_if.sv -----
`timescale 1ns / 1ps

interface clws_strobe_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [7:0] bus_value;
  logic       last;

  modport source (output valid, reg_select, bus_value, last, input ready);
  modport sink (input valid, reg_select, bus_value, last, output ready);
endinterface

// ----- src/clws_bcd.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clws_bcd (
  input  logic                clk,
  input  logic                rst,
  input  clws_pkg::conv_req_t conv_req,
  output logic                busy,
  output clws_pkg::digit_arr_t digits
);
  import clws_pkg::*;

  logic [BIN_W-1:0]    bin;
  logic [CNT_W-1:0]    count;
  digit_arr_t          bcd;
  digit_arr_t          adjusted;
  logic [4*DIGITS-1:0] adj_flat;

  // Shift-and-add-three: every digit of five or more gets three added before each shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adjusted[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  assign adj_flat = adjusted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (conv_req.start) begin
      busy  <= 1'b1;
      count <= CNT_W'(BIN_W - 1);
      bin   <= conv_req.mag;
      bcd   <= '0;
    end else if (busy) begin
      bcd   <= {adj_flat[4*DIGITS-2:0], bin[BIN_W-1]};
      bin   <= {bin[BIN_W-2:0], 1'b0};
      count <= count - CNT_W'(1);
      if (count == '0) busy <= 1'b0;
    end
  end

  assign digits = bcd;

  `ASSERT_NEXT(a_start_busy, conv_req.start, busy, "conversion did not start")

endmodule

// ----- src/clws_seq.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clws_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  clws_pkg::cfg_t       cfg,
  clws_req_if.sink             req,
  clws_strobe_if.source        strobe,
  output clws_pkg::conv_req_t  conv_req,
  input  logic                 conv_busy,
  input  clws_pkg::digit_arr_t digits
);
  import clws_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NIB, S_FS, S_DC, S_CLR, S_CHAR, S_MINUS, S_CONV, S_SKIP, S_DIGIT
  } state_t;

  state_t               state;
  logic                 half;
  logic                 is_init;
  logic [7:0]           char_code;
  logic [DIG_IDX_W-1:0] idx;
  logic                 out_valid;
  logic                 out_rs;
  logic [7:0]           out_bus;
  logic                 out_last;

  logic                 accept;
  logic                 out_free;
  logic                 emitting;
  logic [7:0]           cur_byte;
  logic                 cur_rs;
  logic                 cur_last;
  logic [3:0]           digit;
  logic [BIN_W-1:0]     raw;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || strobe.ready;
  assign digit     = digits[idx];
  assign raw       = req.value;

  assign conv_req.start = accept && (req.func == FUNC_NUMBER);
  assign conv_req.mag   = raw[BIN_W-1] ? (~raw + BIN_W'(1)) : raw;

  always_comb begin
    emitting = state inside {S_NIB, S_FS, S_DC, S_CLR, S_CHAR, S_MINUS, S_DIGIT};
    cur_rs   = state inside {S_CHAR, S_MINUS, S_DIGIT};
    case (state)
      S_NIB:   cur_byte = INIT_NIBBLE;
      S_FS:    cur_byte = fset_byte(cfg);
      S_DC:    cur_byte = dctl_byte(cfg);
      S_CLR:   cur_byte = CMD_CLEAR;
      S_CHAR:  cur_byte = char_code;
      S_MINUS: cur_byte = CH_MINUS;
      S_DIGIT: cur_byte = CH_ZERO | {4'h0, digit};
      default: cur_byte = 8'h00;
    endcase
    case (state)
      S_DC:    cur_last = !is_init;
      S_CLR:   cur_last = 1'b1;
      S_CHAR:  cur_last = 1'b1;
      S_DIGIT: cur_last = (idx == '0);
      default: cur_last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      half      <= 1'b0;
      is_init   <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emitting && out_free) begin
        out_valid <= 1'b1;
        out_rs    <= cur_rs;
        if (state == S_NIB) begin
          out_bus  <= cur_byte;
          out_last <= 1'b0;
          state    <= S_FS;
        end else if (cfg.bus_four_bit && !half) begin
          // High nibble first; the byte state stays for the low nibble.
          out_bus  <= {cur_byte[7:4], 4'h0};
          out_last <= 1'b0;
          half     <= 1'b1;
        end else begin
          out_bus  <= cfg.bus_four_bit ? {cur_byte[3:0], 4'h0} : cur_byte;
          out_last <= cur_last;
          half     <= 1'b0;
          case (state)
            S_FS:    state <= S_DC;
            S_DC:    state <= is_init ? S_CLR : S_IDLE;
            S_MINUS: state <= S_CONV;
            S_DIGIT: begin
              if (idx == '0) state <= S_IDLE;
              else idx <= idx - DIG_IDX_W'(1);
            end
            default: state <= S_IDLE;
          endcase
        end
      end else begin
        if (strobe.ready) out_valid <= 1'b0;
        case (state)
          S_IDLE: begin
            if (accept) begin
              case (req.func)
                FUNC_CHAR: begin
                  char_code <= raw[7:0];
                  state     <= S_CHAR;
                end
                FUNC_NUMBER:   state <= raw[BIN_W-1] ? S_MINUS : S_CONV;
                FUNC_CLEAR:    state <= S_CLR;
                FUNC_SETTINGS: begin
                  is_init <= 1'b0;
                  state   <= S_FS;
                end
                FUNC_INIT: begin
                  is_init <= 1'b1;
                  state   <= cfg.bus_four_bit ? S_NIB : S_FS;
                end
                default: state <= S_IDLE;
              endcase
            end
          end
          S_CONV: begin
            if (!conv_busy) begin
              idx   <= TOP_DIGIT;
              state <= S_SKIP;
            end
          end
          S_SKIP: begin
            // Step past leading zeros, one digit a cycle, keeping at least one.
            if (digit == 4'd0 && idx != '0) idx <= idx - DIG_IDX_W'(1);
            else state <= S_DIGIT;
          end
          default: state <= state;
        endcase
      end
    end
  end

  assign strobe.valid      = out_valid;
  assign strobe.reg_select = out_rs;
  assign strobe.bus_value  = out_bus;
  assign strobe.last       = out_last;

  `ASSERT_IMPLIES(a_conv_start_idle, conv_req.start, !conv_busy, "conversion restarted")
  `ASSERT_IMPLIES(a_digits_settled, state == S_SKIP || state == S_DIGIT, !conv_busy, "digits read early")
  `ASSERT_IMPLIES(a_digit_index, state == S_DIGIT, idx <= TOP_DIGIT, "digit index out of range")

endmodule

// ----- src/char_lcd_write_sequencer_unit.sv -----
`timescale 1ns / 1ps
// Character-LCD write sequencer. Requests arrive on req (func, value) and each
// becomes a run of enable-strobe words on strobe (reg_select, bus_value, last);
// last marks the final word of a request. In 4-bit mode every byte except
// the init nibble goes out as two words, high nibble first, each on bits 7..4.
// One request is taken at a time: req.ready is high only while the sequencer
// is idle. Every word waits in an output register, so a stalled receiver holds
// the sequencer but never loses a word, and the next request is taken while
// the final word of the previous one still waits.
// The first word is registered once the request's first state is reached and
// the output register is free, and further words follow one a cycle while the
// receiver takes them. A number first runs through a shift-and-add-three
// converter that shifts all 32 bits, one bit a cycle; the sequencer then sees
// the converter finish, skips leading zeros one digit at a time, leaves the
// skip and registers each digit word. The next request is taken only once the
// final word has been registered. The configuration registers are written
// through cfg_write_en, cfg_index and cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. Reset
// (rst, synchronous) empties the output register, returns to idle and loads
// 4-bit bus, two lines, small font, display on and cursor off.

module char_lcd_write_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [clws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clws_pkg::CFG_DATA_W-1:0]  cfg_data,
  clws_req_if.sink                         req,
  clws_strobe_if.source                    strobe
);
  import clws_pkg::*;

  cfg_t       cfg;
  conv_req_t  conv_req;
  logic       conv_busy;
  digit_arr_t digits;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bus_four_bit <= 1'b1;
      cfg.two_lines    <= 1'b1;
      cfg.tall_font    <= 1'b0;
      cfg.display_on   <= 1'b1;
      cfg.cursor_mode  <= CURSOR_OFF;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_BUS_FOUR_BIT: cfg.bus_four_bit <= cfg_data[0];
        CFG_TWO_LINES:    cfg.two_lines    <= cfg_data[0];
        CFG_TALL_FONT:    cfg.tall_font    <= cfg_data[0];
        CFG_DISPLAY_ON:   cfg.display_on   <= cfg_data[0];
        CFG_CURSOR_MODE:  cfg.cursor_mode  <= cfg_data[1:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  clws_bcd u_bcd (
    .clk      (clk),
    .rst      (rst),
    .conv_req (conv_req),
    .busy     (conv_busy),
    .digits   (digits)
  );

  clws_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .strobe    (strobe),
    .conv_req  (conv_req),
    .conv_busy (conv_busy),
    .digits    (digits)
  );

endmodule
